[hw/rtl/md5he_pkg.sv]
// Package for the MD5 hash engine: state type, initial values and round tables.
`timescale 1ns / 1ps
`default_nettype none

package md5he_pkg;

   typedef logic [31:0] md5he_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BYTES,
      ST_MARK,
      ST_PAD,
      ST_LEN,
      ST_INIT,
      ST_ROUND,
      ST_FOLD,
      ST_SEND
   } md5he_state_type;

   localparam md5he_word_type INIT_A = 32'h67452301;
   localparam md5he_word_type INIT_B = 32'hEFCDAB89;
   localparam md5he_word_type INIT_C = 32'h98BADCFE;
   localparam md5he_word_type INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_STEP  = 6'd63;
   localparam logic [5:0] LAST_BYTE  = 6'd63;
   localparam logic [5:0] LAST_WORD  = 6'd60;
   localparam logic [2:0] FULL_COUNT = 3'd4;

   // Additive constant of each of the 64 steps.
   function automatic md5he_word_type round_const(input logic [5:0] st);
      md5he_word_type k;
      case (st)
         6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
         6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
         6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
         6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
         6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
         6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
         6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
         6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
         6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
         6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
         6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
         6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
         6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
         6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
         6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
         6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
         6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
         6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
         6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
         6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
         6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
         6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
         6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
         6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
         6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
         6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
         6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
         6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
         6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
         6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
         6'd62: k = 32'h2AD7D2BB;  6'd63: k = 32'hEB86D391;
         default: k = 32'hEB86D391;
      endcase
      return k;
   endfunction

   // Left rotation of each step: four amounts per group of sixteen steps.
   function automatic logic [4:0] rot_amount(input logic [5:0] st);
      logic [4:0] r;
      case ({st[5:4], st[1:0]})
         4'd0:  r = 5'd7;   4'd1:  r = 5'd12;  4'd2:  r = 5'd17;  4'd3:  r = 5'd22;
         4'd4:  r = 5'd5;   4'd5:  r = 5'd9;   4'd6:  r = 5'd14;  4'd7:  r = 5'd20;
         4'd8:  r = 5'd4;   4'd9:  r = 5'd11;  4'd10: r = 5'd16;  4'd11: r = 5'd23;
         4'd12: r = 5'd6;   4'd13: r = 5'd10;  4'd14: r = 5'd15;  4'd15: r = 5'd21;
         default: r = 5'd7;
      endcase
      return r;
   endfunction

   // Message word used by a step; the index is formed mod 16 from the step's low four bits, its top two pick the round.
   function automatic logic [3:0] msg_index(input logic [5:0] st);
      logic [3:0] l;
      logic [3:0] m;
      l = st[3:0];
      case (st[5:4])
         2'd0:    m = l;
         2'd1:    m = (l << 2) + l + 4'd1;
         2'd2:    m = (l << 1) + l + 4'd5;
         2'd3:    m = (l << 3) - l;
         default: m = l;
      endcase
      return m;
   endfunction

   function automatic md5he_word_type rotl32(input md5he_word_type v, input logic [4:0] s);
      logic [63:0] w;
      w = {v, v} << s;
      return w[63:32];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/md5_hash_engine_unit.sv]
// MD5 hash engine: byte packing, padding, one-step-per-cycle compression and digest output.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// req_      in         tdata: data_word; tuser: byte_count; tlast: last_item
// rsp_      out        tdata: digest_word; tuser: word_index; tlast: final_word
//
// A full request on a word boundary of the block buffer is written as a whole word; any other
// request is unpacked byte by byte. Each full 64-byte block then passes through the single
// round unit: the working words are loaded, 64 steps run, and the result is folded into the chain.
// A last request adds the 0x80 mark, zero fill (a word per cycle when aligned, paused while a
// full block is compressed), the two length words and one or two compressions, then four
// digest words, one per beat. req_tready is high only while idle, rsp_tready may stall the
// digest words without limit, and the synchronous reset restores the standard chaining values.
module md5_hash_engine_unit
   import md5he_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] data_word
   input  wire logic [2:0]  req_tuser,   // [2:0] byte_count
   input  wire logic        req_tlast,   // last_item

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] digest_word
   output logic [1:0]       rsp_tuser,   // [1:0] word_index
   output logic             rsp_tlast    // final_word
);

   md5he_state_type state_ff, state_in;
   md5he_state_type ret_ff, ret_in;      // where to resume after a compression

   logic [5:0]     fill_ff, fill_in;
   logic [63:0]    total_ff, total_in;
   logic [5:0]     step_ff, step_in;
   logic [31:0]    data_ff, data_in;
   logic [2:0]     cnt_ff, cnt_in;
   logic           last_ff, last_in;
   logic [1:0]     widx_ff, widx_in;
   md5he_word_type tmp_ff, tmp_in;
   md5he_word_type chain_ff [4];
   md5he_word_type chain_in [4];
   md5he_word_type work_ff [4];
   md5he_word_type work_in [4];
   md5he_word_type buf_ff [16];

   // Block buffer write port.
   logic           wr_en;
   logic [3:0]     wr_addr;
   logic [3:0]     wr_be;
   md5he_word_type wr_data;
   logic           len_wr;

   logic [2:0]     cnt_clamp;
   logic [5:0]     rd_step;
   md5he_word_type msg_word;
   md5he_word_type f_val;
   md5he_word_type b_new;
   md5he_word_type add_base;
   logic [63:0]    bit_len;
   md5he_state_type after_word;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tdata  = chain_ff[widx_ff];
   assign rsp_tuser  = widx_ff;
   assign rsp_tlast  = (widx_ff == 2'd3);

   // Counts above four are taken as four.
   assign cnt_clamp = (req_tuser > FULL_COUNT) ? FULL_COUNT : req_tuser;
   assign bit_len   = {total_ff[60:0], 3'b000};

   // The next step's sum a + K + M is formed ahead of time and registered in tmp_ff: its a is today's d.
   assign rd_step  = (state_ff == ST_ROUND) ? step_ff + 6'd1 : 6'd0;
   assign msg_word = buf_ff[msg_index(rd_step)];
   assign add_base = (state_ff == ST_ROUND) ? work_ff[3] : chain_ff[0];

   always_comb begin
      case (step_ff[5:4])
         2'd0:    f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         2'd1:    f_val = (work_ff[1] & work_ff[3]) | (work_ff[2] & ~work_ff[3]);
         2'd2:    f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         2'd3:    f_val = work_ff[2] ^ (work_ff[1] | ~work_ff[3]);
         default: f_val = '0;
      endcase
   end

   assign b_new = work_ff[1] + rotl32(tmp_ff + f_val, rot_amount(step_ff));

   assign after_word = req_tlast ? ST_MARK : ST_IDLE;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      step_in  = step_ff;
      data_in  = data_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      widx_in  = widx_ff;
      tmp_in   = tmp_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      wr_en    = 1'b0;
      wr_addr  = fill_ff[5:2];
      wr_be    = 4'b0001 << fill_ff[1:0];
      wr_data  = '0;
      len_wr   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if ((fill_ff[1:0] == 2'd0) && (cnt_clamp == FULL_COUNT)) begin
                  // Aligned full word goes straight into the buffer.
                  wr_en    = 1'b1;
                  wr_be    = 4'hF;
                  wr_data  = req_tdata;
                  fill_in  = fill_ff + 6'd4;
                  total_in = total_ff + 64'd4;
                  if (fill_ff == LAST_WORD) begin
                     ret_in   = after_word;
                     state_in = ST_INIT;
                  end else begin
                     state_in = after_word;
                  end
               end else begin
                  data_in  = req_tdata;
                  cnt_in   = cnt_clamp;
                  last_in  = req_tlast;
                  state_in = ST_BYTES;
               end
            end
         end

         ST_BYTES: begin
            if (cnt_ff == 3'd0) begin
               state_in = last_ff ? ST_MARK : ST_IDLE;
            end else begin
               wr_en    = 1'b1;
               wr_data  = {4{data_ff[7:0]}};
               data_in  = data_ff >> 8;
               cnt_in   = cnt_ff - 3'd1;
               fill_in  = fill_ff + 6'd1;
               total_in = total_ff + 64'd1;
               if (fill_ff == LAST_BYTE) begin
                  ret_in   = ST_BYTES;
                  state_in = ST_INIT;
               end
            end
         end

         ST_MARK: begin
            wr_en   = 1'b1;
            wr_data = {4{PAD_MARK}};
            fill_in = fill_ff + 6'd1;
            ret_in  = ST_PAD;
            state_in = (fill_ff == LAST_BYTE) ? ST_INIT : ST_PAD;
         end

         ST_PAD: begin
            if (fill_ff == LEN_OFFSET) begin
               state_in = ST_LEN;
            end else if (fill_ff[1:0] == 2'd0) begin
               wr_en   = 1'b1;
               wr_be   = 4'hF;
               fill_in = fill_ff + 6'd4;
               ret_in  = ST_PAD;
               if (fill_ff == LAST_WORD) begin
                  state_in = ST_INIT;
               end
            end else begin
               wr_en   = 1'b1;
               fill_in = fill_ff + 6'd1;
               ret_in  = ST_PAD;
               if (fill_ff == LAST_BYTE) begin
                  state_in = ST_INIT;
               end
            end
         end

         ST_LEN: begin
            len_wr   = 1'b1;
            fill_in  = '0;
            ret_in   = ST_SEND;
            state_in = ST_INIT;
         end

         ST_INIT: begin
            work_in  = chain_ff;
            tmp_in   = add_base + round_const(rd_step) + msg_word;
            step_in  = '0;
            state_in = ST_ROUND;
         end

         ST_ROUND: begin
            work_in[0] = work_ff[3];
            work_in[1] = b_new;
            work_in[2] = work_ff[1];
            work_in[3] = work_ff[2];
            tmp_in     = add_base + round_const(rd_step) + msg_word;
            step_in    = step_ff + 6'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FOLD;
            end
         end

         ST_FOLD: begin
            for (int i = 0; i < 4; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            state_in = ret_ff;
         end

         ST_SEND: begin
            if (rsp_tready) begin
               widx_in = widx_ff + 2'd1;
               if (widx_ff == 2'd3) begin
                  chain_in[0] = INIT_A;
                  chain_in[1] = INIT_B;
                  chain_in[2] = INIT_C;
                  chain_in[3] = INIT_D;
                  total_in    = '0;
                  state_in    = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ret_ff      <= ST_IDLE;
         fill_ff     <= '0;
         total_ff    <= '0;
         step_ff     <= '0;
         widx_ff     <= '0;
         chain_ff[0] <= INIT_A;
         chain_ff[1] <= INIT_B;
         chain_ff[2] <= INIT_C;
         chain_ff[3] <= INIT_D;
         work_ff[0]  <= '0;
         work_ff[1]  <= '0;
         work_ff[2]  <= '0;
         work_ff[3]  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         step_ff  <= step_in;
         widx_ff  <= widx_in;
         chain_ff <= chain_in;
         work_ff  <= work_in;
      end
   end

   // Payload registers and the block buffer carry no reset.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
      tmp_ff  <= tmp_in;
      if (wr_en) begin
         for (int b = 0; b < 4; b++) begin
            if (wr_be[b]) begin
               buf_ff[wr_addr][8*b +: 8] <= wr_data[8*b +: 8];
            end
         end
      end
      if (len_wr) begin
         buf_ff[14] <= bit_len[31:0];
         buf_ff[15] <= bit_len[63:32];
      end
   end

   // The engine never takes a request while a digest is on offer.
   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid))
      else $error("request taken while digest pending");

   // The step counter rests at zero outside the rounds.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) |-> (step_ff == 6'd0))
      else $error("step counter not at rest");

   // Length words are always placed at the padding offset.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN) |-> (fill_ff == LEN_OFFSET))
      else $error("length written at wrong offset");

   // After the last digest word the chaining values and byte count restart.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=>
         (chain_ff[0] == INIT_A && chain_ff[3] == INIT_D && total_ff == 64'd0))
      else $error("engine did not restart after digest");

endmodule

`default_nettype wire

[verif/md5_digest_checker.sv]
// Checker for the MD5 hash engine: predicts each digest from the accepted requests and compares it.
`timescale 1ns / 1ps

module md5_digest_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic [2:0]  req_tuser,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        rsp_tlast,
   output int               mismatch_count,
   output int               digest_words_pending
);

   localparam logic [31:0] CHAIN_A = 32'h67452301;
   localparam logic [31:0] CHAIN_B = 32'hEFCDAB89;
   localparam logic [31:0] CHAIN_C = 32'h98BADCFE;
   localparam logic [31:0] CHAIN_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam int unsigned LENGTH_POS = 56;
   localparam int unsigned BLOCK_BYTES = 64;
   localparam logic [2:0]  WORD_BYTES = 3'd4;

   localparam logic [31:0] STEP_K [64] = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
      32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
      32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
      32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
      32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
      32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
      32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
      32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
      32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
      32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
      32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
   };

   localparam int unsigned STEP_ROT [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  position;
      logic        closing;
   } digest_beat_type;

   logic [31:0]     chain_h [4];
   logic [31:0]     block_words [16];
   int unsigned     block_fill;
   logic [63:0]     message_bytes;
   digest_beat_type digest_due [$];
   digest_beat_type due_beat;

   task automatic restart_chain();
      chain_h[0] = CHAIN_A;
      chain_h[1] = CHAIN_B;
      chain_h[2] = CHAIN_C;
      chain_h[3] = CHAIN_D;
      message_bytes = '0;
   endtask

   task automatic compress_block();
      logic [31:0] a, b, c, d, f, t;
      int unsigned s, g, idx, r;
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      for (s = 0; s < 64; s++) begin
         g = s / 16;
         case (g)
            0: begin
               f = (b & c) | (~b & d);
               idx = s % 16;
            end
            1: begin
               f = (b & d) | (c & ~d);
               idx = (5 * s + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               idx = (3 * s + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               idx = (7 * s) % 16;
            end
         endcase
         t = a + f + STEP_K[s] + block_words[idx];
         r = STEP_ROT[4 * g + s % 4];
         a = d;
         d = c;
         c = b;
         b = b + ((t << r) | (t >> (32 - r)));
      end
      chain_h[0] = chain_h[0] + a;
      chain_h[1] = chain_h[1] + b;
      chain_h[2] = chain_h[2] + c;
      chain_h[3] = chain_h[3] + d;
   endtask

   task automatic push_byte(input logic [7:0] v);
      block_words[block_fill / 4][8 * (block_fill % 4) +: 8] = v;
      block_fill++;
      if (block_fill == BLOCK_BYTES) begin
         compress_block();
         block_fill = 0;
      end
   endtask

   // Appends the valid bytes of one request; a last request closes the message.
   task automatic absorb_request(input logic [31:0] w, input logic [2:0] n, input logic l);
      int unsigned valid, i;
      logic [63:0] bit_len;
      digest_beat_type beat;
      valid = (n > WORD_BYTES) ? WORD_BYTES : n;
      for (i = 0; i < valid; i++) begin
         push_byte(w[8 * i +: 8]);
         message_bytes = message_bytes + 64'd1;
      end
      if (l) begin
         bit_len = message_bytes << 3;
         push_byte(PAD_BYTE);
         while (block_fill != LENGTH_POS)
            push_byte(8'h00);
         block_words[14] = bit_len[31:0];
         block_words[15] = bit_len[63:32];
         compress_block();
         block_fill = 0;
         for (i = 0; i < 4; i++) begin
            beat.word = chain_h[i];
            beat.position = 2'(i);
            beat.closing = (i == 3);
            digest_due.push_back(beat);
         end
         restart_chain();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_chain();
         block_fill = 0;
         for (int k = 0; k < 16; k++)
            block_words[k] = '0;
         digest_due.delete();
         mismatch_count = 0;
      end else begin
         // Responses first: a digest word never belongs to a request taken at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (digest_due.size() == 0) begin
               $error("digest word 0x%08h arrived with no digest due", rsp_tdata);
               mismatch_count++;
            end else begin
               due_beat = digest_due.pop_front();
               if (rsp_tdata !== due_beat.word) begin
                  $error("digest_word: expected 0x%08h, got 0x%08h", due_beat.word, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== due_beat.position) begin
                  $error("word_index: expected %0d, got %0d", due_beat.position, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tlast !== due_beat.closing) begin
                  $error("final_word: expected %0b, got %0b", due_beat.closing, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            absorb_request(req_tdata, req_tuser, req_tlast);
      end
      digest_words_pending = digest_due.size();
   end

endmodule

[verif/tb.sv]
// Testbench top for the MD5 hash engine: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module tb;

   // Each request carries up to four message bytes; the digest comes back as four words.
   localparam logic [2:0] FULL_WORD = 3'd4;
   localparam int unsigned RANDOM_REQUESTS = 130;
   localparam int unsigned SETTLE_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // Percentages of cycles in which each side holds back.
   int sender_idle_pct = 24;
   int receiver_idle_pct = 84;

   int mismatch_count;
   int digest_words_pending;
   int unsigned random_requests = 0;

   always #1 clock = ~clock;

   md5_hash_engine_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   md5_digest_checker u_digest_checker (
      .clock                (clock),
      .reset                (reset),
      .req_tvalid           (req_tvalid),
      .req_tready           (req_tready),
      .req_tdata            (req_tdata),
      .req_tuser            (req_tuser),
      .req_tlast            (req_tlast),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_tdata            (rsp_tdata),
      .rsp_tuser            (rsp_tuser),
      .rsp_tlast            (rsp_tlast),
      .mismatch_count       (mismatch_count),
      .digest_words_pending (digest_words_pending)
   );

   // The receiver stalls at random, a fresh decision every cycle, so that back-pressure
   // lands on any of the four digest words.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Offers one request, after a random number of idle cycles, and returns at the edge
   // at which it is taken. The valid is only ever assigned once per edge.
   task automatic send_word(input logic [31:0] w, input logic [2:0] n, input logic l);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= n;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Withdraws the request and waits until every predicted digest word has been taken.
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (digest_words_pending != 0)
         @(posedge clock);
   endtask

   // A message of random length and content. Most requests are full words; now and then
   // a short word sits mid-message, and the closing request carries any count at all,
   // counts above four included.
   task automatic send_random_message();
      int unsigned body, i;
      logic [2:0] n;
      case ($urandom_range(9))
         0:       body = $urandom_range(40, 30);
         1, 2, 3: body = $urandom_range(16, 12);
         default: body = $urandom_range(11, 0);
      endcase
      for (i = 0; i < body; i++) begin
         n = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : FULL_WORD;
         send_word($urandom, n, 1'b0);
         random_requests++;
      end
      n = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_word($urandom, n, 1'b1);
      random_requests++;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The empty message: a closing request with no bytes and nothing before it.
      send_word(32'h0000_0000, 3'd0, 1'b1);
      // Three bytes only; the unused top byte is all ones and must be ignored.
      send_word(32'hFF63_6261, 3'd3, 1'b1);
      // Extremes of the data word, closing on a full word.
      send_word(32'hFFFF_FFFF, FULL_WORD, 1'b0);
      send_word(32'h0000_0000, FULL_WORD, 1'b0);
      send_word(32'hA5A5_A5A5, FULL_WORD, 1'b1);
      // Short words in mid-message, so the rest of the message runs off word alignment.
      send_word(32'h1122_3344, 3'd1, 1'b0);
      send_word(32'h5566_7788, 3'd2, 1'b0);
      send_word(32'h99AA_BBCC, FULL_WORD, 1'b1);
      // Byte counts above four, which the engine treats as four.
      send_word(32'hDEAD_BEEF, 3'd5, 1'b0);
      send_word(32'h0123_4567, 3'd6, 1'b0);
      send_word(32'h89AB_CDEF, 3'd7, 1'b1);
      // Fifty-six bytes leave no room for the length, so padding spills into a second block.
      repeat (14)
         send_word($urandom, FULL_WORD, 1'b0);
      send_word($urandom, 3'd0, 1'b1);

      // The sender sits still until the last digest has gone, then the random part begins.
      hold_until_drained();

      while (random_requests < RANDOM_REQUESTS) begin
         if (random_requests >= RANDOM_REQUESTS / 3 && sender_idle_pct == 24) begin
            hold_until_drained();
            sender_idle_pct = 84;
            receiver_idle_pct = 24;
         end else if (random_requests >= 2 * RANDOM_REQUESTS / 3 && sender_idle_pct == 84) begin
            hold_until_drained();
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         send_random_message();
      end

      // Let the last digest drain, then watch a while longer for stray words.
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && digest_words_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
